@@ rtl/lbg_pkg.sv @@
// shared types, codes and constants for the linear binning grid accumulator
`timescale 1ns / 1ps
package lbg_pkg;

  localparam int GRID_MAX   = 1024;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COUNT_W    = 48;
  localparam int DIV_W      = 33;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_LOW      = 3'd0,
    REG_BIN_WIDTH     = 3'd1,
    REG_GRID_POINTS   = 3'd2,
    REG_TRUNCATE_ENDS = 3'd3,
    REG_LINEAR_MODE   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] sample;
    logic signed [31:0] weight;
    logic [9:0]         read_index;
  } item_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] grid_count;
    logic [9:0]                grid_index;
  } result_t;

  typedef enum logic [1:0] {
    RD_ITEM   = 2'd0,
    RD_CELL_A = 2'd1,
    RD_CELL_B = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_CLEAR  = 2'd1,
    WR_CELL_A = 2'd2,
    WR_CELL_B = 2'd3
  } wr_sel_t;

  typedef struct packed {
    logic    load_item;
    logic    clr_init;
    logic    div_load_pos;
    logic    div_load_frac;
    logic    div_step;
    logic    plan;
    logic    mul;
    logic    fin;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic drop;
    logic split;
  } dp_stat_t;

endpackage

@@ rtl/lbg_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module lbg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lbg_div.sv @@
// restoring divider, one quotient bit per cycle while step is high
`timescale 1ns / 1ps
module lbg_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic                       step,
  input  logic [30:0]                divisor,
  input  logic [30:0]                rem_init,
  input  logic [lbg_pkg::DIV_W-1:0]  num_init,
  output logic [lbg_pkg::DIV_W-1:0]  quo,
  output logic [30:0]                rem,
  output logic                       last
);

  localparam int CW = $clog2(lbg_pkg::DIV_W + 1);

  logic [CW-1:0] cnt;
  logic [31:0]   trial;
  logic [32:0]   diff;

  // partial remainder stays below the divisor, so 31 bits hold it
  assign trial = {rem, quo[lbg_pkg::DIV_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor};
  assign last  = (cnt == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= CW'(lbg_pkg::DIV_W);
    end else if (step && cnt != '0) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= rem_init;
      quo <= num_init;
    end else if (step && cnt != '0) begin
      if (!diff[32]) begin
        rem <= diff[30:0];
        quo <= {quo[lbg_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[30:0];
        quo <= {quo[lbg_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/lbg_dp.sv @@
// datapath: configuration, cell placement, weight split, count store
`timescale 1ns / 1ps
module lbg_dp #(
  parameter int GRID_MAX = lbg_pkg::GRID_MAX
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  lbg_pkg::item_t               item,
  input  lbg_pkg::dp_cmd_t             cmd,
  output lbg_pkg::dp_stat_t            stat,
  output lbg_pkg::result_t             result,
  output logic                         result_valid
);

  localparam int AW = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int MW = $clog2(GRID_MAX + 1);
  localparam int CW = lbg_pkg::COUNT_W;

  // configuration
  logic signed [31:0] grid_low;
  logic [30:0]        bin_width;
  logic [10:0]        grid_points;
  logic               truncate_ends;
  logic               linear_mode;

  lbg_pkg::item_t     it;
  logic [30:0]        bw_eff;
  logic signed [32:0] diff;
  logic               d_neg;
  logic [32:0]        d_mag;
  logic [31:0]        m_wide;
  logic [MW-1:0]      m_eff;
  logic [32:0]        q;
  logic               interior;
  logic [AW-1:0]      bin_idx;

  logic [lbg_pkg::DIV_W-1:0] div_quo;
  logic [30:0]               div_rem;
  logic                      div_last;
  logic [30:0]               div_rem_init;
  logic [lbg_pkg::DIV_W-1:0] div_num_init;

  logic signed [31:0] mul_a;
  logic signed [63:0] mul_p;
  logic signed [63:0] prod;
  logic [63:0]        prod_mag;
  logic               frac_neg;
  logic signed [33:0] next_part;

  logic [AW-1:0]      addr_a;
  logic [AW-1:0]      addr_b;
  logic signed [33:0] val_a;
  logic signed [33:0] val_b;
  logic [AW-1:0]      clr_cnt;

  logic [AW+9:0]      ri_ext;
  logic               in_range;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [CW-1:0]      ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [CW-1:0]      ram_rdata;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] cur,
                                            input logic signed [33:0] inc);
    logic signed [CW+1:0] sum;
    sum = (CW+2)'($signed(cur)) + (CW+2)'(inc);
    if (sum[CW+1:CW-1] == 3'b000 || sum[CW+1:CW-1] == 3'b111) begin
      sat_add = sum[CW-1:0];
    end else if (sum[CW+1]) begin
      sat_add = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat_add = {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_low      <= '0;
      bin_width     <= 31'd65536;
      grid_points   <= 11'd401;
      truncate_ends <= 1'b0;
      linear_mode   <= 1'b1;
    end else if (cfg_we) begin
      case (lbg_pkg::reg_idx_t'(cfg_index))
        lbg_pkg::REG_GRID_LOW:      grid_low      <= cfg_data;
        lbg_pkg::REG_BIN_WIDTH:     bin_width     <= cfg_data[30:0];
        lbg_pkg::REG_GRID_POINTS:   grid_points   <= cfg_data[10:0];
        lbg_pkg::REG_TRUNCATE_ENDS: truncate_ends <= cfg_data[0];
        lbg_pkg::REG_LINEAR_MODE:   linear_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it <= item;
    end
  end

  assign bw_eff = (bin_width == '0) ? 31'd1 : bin_width;
  assign diff   = 33'(it.sample) - 33'(grid_low);
  assign d_neg  = diff[32];
  assign d_mag  = d_neg ? 33'(-diff) : 33'(diff);

  always_comb begin
    if (grid_points < 11'd3) begin
      m_wide = 32'd3;
    end else if (32'(grid_points) > 32'(GRID_MAX)) begin
      m_wide = 32'(GRID_MAX);
    end else begin
      m_wide = 32'(grid_points);
    end
  end
  assign m_eff = MW'(m_wide);

  // placement from the truncated quotient; a positive cell needs a non-negative offset
  assign q        = div_quo;
  assign interior = !d_neg && (q != '0) && (q < 33'(m_eff) - 33'd1);

  always_comb begin
    if (interior) begin
      bin_idx = q[AW-1:0];
    end else if (d_neg || q == '0) begin
      bin_idx = '0;
    end else if (linear_mode) begin
      bin_idx = AW'(m_eff - MW'(1));
    end else begin
      bin_idx = AW'(m_eff - MW'(2));
    end
  end

  assign stat.drop     = !interior && truncate_ends;
  assign stat.split    = interior && linear_mode;
  assign stat.div_last = div_last;
  assign stat.clr_last = (clr_cnt == AW'(GRID_MAX - 1));

  // fraction pass: |r*w| < 2^62, upper part already below the divisor
  assign prod_mag     = prod[63] ? 64'(-prod) : 64'(prod);
  assign div_rem_init = cmd.div_load_frac ? {1'b0, prod_mag[62:33]} : '0;
  assign div_num_init = cmd.div_load_frac ? prod_mag[32:0] : d_mag;

  lbg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd.div_load_pos | cmd.div_load_frac),
    .step     (cmd.div_step),
    .divisor  (bw_eff),
    .rem_init (div_rem_init),
    .num_init (div_num_init),
    .quo      (div_quo),
    .rem      (div_rem),
    .last     (div_last)
  );

  assign mul_a     = $signed({1'b0, div_rem});
  assign mul_p     = mul_a * it.weight;
  assign next_part = frac_neg ? 34'(-$signed({1'b0, div_quo})) : 34'($signed({1'b0, div_quo}));

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= mul_p;
    end
    if (cmd.div_load_frac) begin
      frac_neg <= prod[63];
    end
    if (cmd.plan) begin
      addr_a <= bin_idx;
      val_a  <= 34'(it.weight);
    end else if (cmd.fin) begin
      val_a <= 34'(it.weight) - next_part;
      val_b <= next_part;
    end
  end

  assign addr_b = addr_a + AW'(1);

  // clearing sweep position
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_init) begin
      clr_cnt <= '0;
    end else if (cmd.wr_sel == lbg_pkg::WR_CLEAR) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  assign ri_ext   = (AW+10)'(it.read_index);
  assign in_range = 32'(it.read_index) < 32'(GRID_MAX);

  always_comb begin
    case (cmd.rd_sel)
      lbg_pkg::RD_ITEM:   ram_raddr = ri_ext[AW-1:0];
      lbg_pkg::RD_CELL_A: ram_raddr = addr_a;
      lbg_pkg::RD_CELL_B: ram_raddr = addr_b;
      default:            ram_raddr = addr_a;
    endcase
  end

  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = clr_cnt;
    ram_wdata = '0;
    case (cmd.wr_sel)
      lbg_pkg::WR_CLEAR: begin
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      lbg_pkg::WR_CELL_A: begin
        ram_waddr = addr_a;
        ram_wdata = sat_add(ram_rdata, val_a);
      end
      lbg_pkg::WR_CELL_B: begin
        ram_waddr = addr_b;
        ram_wdata = sat_add(ram_rdata, val_b);
      end
      default: ram_we = 1'b0;
    endcase
  end

  lbg_ram #(
    .WIDTH (CW),
    .DEPTH (GRID_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.grid_count <= in_range ? ram_rdata : '0;
      result.grid_index <= it.read_index;
    end
  end

endmodule

@@ rtl/lbg_ctl.sv @@
// controller: sequences clear sweep, add and read through the datapath
`timescale 1ns / 1ps
module lbg_ctl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lbg_pkg::op_t      item_op,
  input  lbg_pkg::dp_stat_t stat,
  output lbg_pkg::dp_cmd_t  cmd,
  output logic              busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_DLOAD1,
    S_DIV1,
    S_PLAN,
    S_MUL,
    S_DLOAD2,
    S_DIV2,
    S_FIN,
    S_RD_A,
    S_WR_A,
    S_RD_B,
    S_WR_B,
    S_RD_REQ,
    S_RD_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   two_cells;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      two_cells <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_PLAN) begin
        two_cells <= stat.split;
      end
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          case (item_op)
            lbg_pkg::OP_CLEAR: begin
              cmd.clr_init = 1'b1;
              state_next   = S_CLEAR;
            end
            lbg_pkg::OP_ADD:  state_next = S_DLOAD1;
            lbg_pkg::OP_READ: state_next = S_RD_REQ;
            default:          state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.wr_sel = lbg_pkg::WR_CLEAR;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_DLOAD1: begin
        cmd.div_load_pos = 1'b1;
        state_next       = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_PLAN;
        end
      end
      S_PLAN: begin
        cmd.plan = 1'b1;
        if (stat.drop) begin
          state_next = S_IDLE;
        end else if (stat.split) begin
          state_next = S_MUL;
        end else begin
          state_next = S_RD_A;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DLOAD2;
      end
      S_DLOAD2: begin
        cmd.div_load_frac = 1'b1;
        state_next        = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_RD_A;
      end
      S_RD_A: begin
        cmd.rd_sel = lbg_pkg::RD_CELL_A;
        state_next = S_WR_A;
      end
      S_WR_A: begin
        cmd.wr_sel = lbg_pkg::WR_CELL_A;
        state_next = two_cells ? S_RD_B : S_IDLE;
      end
      S_RD_B: begin
        cmd.rd_sel = lbg_pkg::RD_CELL_B;
        state_next = S_WR_B;
      end
      S_WR_B: begin
        cmd.wr_sel = lbg_pkg::WR_CELL_B;
        state_next = S_IDLE;
      end
      S_RD_REQ: begin
        cmd.rd_sel = lbg_pkg::RD_ITEM;
        state_next = S_RD_OUT;
      end
      S_RD_OUT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/linear_binning_grid_accumulator.sv @@
// top level of the linear binning grid accumulator
`timescale 1ns / 1ps
// Weighted grid binning into a GRID_MAX-entry store of 48-bit saturating counts.
// An item is taken when start is high and busy is low; busy stays high while
// it is worked on. After reset, and after a clear item, busy is high while
// the store is swept to zero, one entry a cycle. An add item runs a restoring
// division by the bin width; a sample that lands whole on one entry then takes
// one read-modify-write (none if dropped), and a linear split adds a multiply,
// a second division of the fraction and a second read-modify-write. A read item
// keeps busy high while the entry is read; its result appears in the cycle in
// which busy goes low, marked by result_valid for exactly one cycle; there is
// no way to hold results off, so the receiver must take each one as it
// appears. Configuration writes are taken at once and should only be made
// while busy is low.
module linear_binning_grid_accumulator #(
  parameter int GRID_MAX = lbg_pkg::GRID_MAX
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  lbg_pkg::item_t                 item,
  output lbg_pkg::result_t               result,
  output logic                           result_valid,
  input  logic                           cfg_we,
  input  logic [lbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbg_pkg::CFG_DATA_W-1:0] cfg_data
);

  lbg_pkg::dp_cmd_t  cmd;
  lbg_pkg::dp_stat_t stat;

  lbg_ctl u_ctl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item_op (item.op),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  lbg_dp #(
    .GRID_MAX (GRID_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule
